@@ sv/vqtbd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and the color unpack function of the VQ texture decoder.
// No dependencies.
package vqtbd_pkg;

    localparam int CB_DEPTH  = 1024;
    localparam int CB_AW     = $clog2(CB_DEPTH);
    localparam int SIDE_LOG2 = 10;

    localparam int            POS_W     = 10;
    localparam logic [POS_W-1:0] SIDE_MASK = POS_W'((1 << SIDE_LOG2) - 1);

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam logic REG_COLOR_FORMAT   = 1'b0;
    localparam logic REG_SMALL_CODEBOOK = 1'b1;

    localparam logic [1:0] FMT_ARGB1555 = 2'd0;
    localparam logic [1:0] FMT_RGB565   = 2'd1;
    localparam logic [1:0] FMT_ARGB4444 = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    function automatic rgb_t unpack_color(input logic [15:0] w, input logic [1:0] fmt);
        rgb_t c;
        case (fmt)
            FMT_ARGB1555:
            begin
                c.red   = {w[14:10], 3'b000};
                c.green = {w[9:5], 3'b000};
                c.blue  = {w[4:0], 3'b000};
            end
            FMT_ARGB4444:
            begin
                c.red   = {w[11:8], 4'b0000};
                c.green = {w[7:4], 4'b0000};
                c.blue  = {w[3:0], 4'b0000};
            end
            default:
            begin
                c.red   = {w[15:11], 3'b000};
                c.green = {w[10:5], 2'b00};
                c.blue  = {w[4:0], 3'b000};
            end
        endcase
        return c;
    endfunction

endpackage

@@ sv/vqtbd_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
module vqtbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/vq_texture_block_decoder.sv @@
`timescale 1ns / 1ps
// VQ texture block decoder: a load transfer writes one codebook word, a decode transfer
// yields four (full codebook) or eight (small codebook) pixels, one per cycle while the
// output is not stalled. Pipeline: pixel sequencer and address, codebook RAM read, color
// unpack into the output register. A byte holds the sequencer until its last pixel is
// issued; load and decode transfers are accepted only while the sequencer is idle or
// issuing the previous byte's last pixel. The codebook is not cleared at reset; entries
// must be written before they are read, which the block itself does not enforce.
// Depends on vqtbd_pkg and vqtbd_ram.
module vq_texture_block_decoder
    import vqtbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [9:0]  code_addr,
    input  logic [15:0] code_word,
    input  logic [17:0] data_offset,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  pix_x,
    output logic [9:0]  pix_y,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        last
);

    logic [1:0] color_format_reg;
    logic       small_codebook_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_format_reg   <= FMT_RGB565;
            small_codebook_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLOR_FORMAT:   color_format_reg   <= cfg_data;
                default:            small_codebook_reg <= cfg_data[0];
            endcase
        end
    end

    // Stage 0: pixel sequencer
    logic             s0_valid_reg, s0_valid_next;
    logic [2:0]       s0_cnt_reg, s0_cnt_next;
    logic [POS_W-1:0] s0_x_reg, s0_x_next;
    logic [POS_W-1:0] s0_y_reg, s0_y_next;
    logic [7:0]       s0_byte_reg, s0_byte_next;
    logic             s0_small_reg, s0_small_next;

    // Stage 1: codebook read
    logic             s1_valid_reg;
    logic [POS_W-1:0] s1_x_reg;
    logic [POS_W-1:0] s1_y_reg;
    logic             s1_last_reg;
    logic             s1_hit_reg;

    // Stage 2: output register
    logic             s2_valid_reg;
    logic [POS_W-1:0] s2_x_reg;
    logic [POS_W-1:0] s2_y_reg;
    rgb_t             s2_rgb_reg;
    logic             s2_last_reg;

    logic s1_en;
    logic s2_en;
    logic s0_adv;
    logic s0_last;
    logic in_xfer;

    logic [8:0]       even_bits;
    logic [8:0]       odd_bits;
    logic [7:0]       entry;
    logic [9:0]       rd_addr;
    logic             rd_hit;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [15:0]      rd_word;
    logic             wr_en;

    assign s2_en   = !s2_valid_reg || !out_stall;
    assign s1_en   = !s1_valid_reg || s2_en;
    assign s0_adv  = s0_valid_reg && s1_en;
    assign s0_last = s0_small_reg ? (s0_cnt_reg == 3'd7) : (s0_cnt_reg == 3'd3);

    assign in_stall = s0_valid_reg && !(s1_en && s0_last);
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            even_bits[k] = data_offset[2 * k];
            odd_bits[k]  = data_offset[2 * k + 1];
        end
    end

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        s0_cnt_next   = s0_cnt_reg;
        s0_x_next     = s0_x_reg;
        s0_y_next     = s0_y_reg;
        s0_byte_next  = s0_byte_reg;
        s0_small_next = s0_small_reg;
        if (in_xfer && cmd == CMD_DECODE)
        begin
            s0_valid_next = 1'b1;
            s0_cnt_next   = 3'd0;
            s0_byte_next  = data_byte;
            s0_small_next = small_codebook_reg;
            if (small_codebook_reg)
            begin
                s0_x_next = {even_bits, 1'b0};
                s0_y_next = {odd_bits[7:0], 2'b00};
            end
            else
            begin
                s0_x_next = {odd_bits, 1'b0};
                s0_y_next = {even_bits, 1'b0};
            end
        end
        else if (s0_adv)
        begin
            if (s0_last)
            begin
                s0_valid_next = 1'b0;
            end
            else
            begin
                s0_cnt_next = s0_cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s0_cnt_reg   <= 3'd0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s0_cnt_reg   <= s0_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_x_reg     <= s0_x_next;
        s0_y_reg     <= s0_y_next;
        s0_byte_reg  <= s0_byte_next;
        s0_small_reg <= s0_small_next;
    end

    // slot order within a quad: 0, 2, 1, 3
    always_comb
    begin
        if (!s0_small_reg)
        begin
            entry = s0_byte_reg;
        end
        else if (s0_cnt_reg[2])
        begin
            entry = {4'd0, s0_byte_reg[7:4]};
        end
        else
        begin
            entry = {4'd0, s0_byte_reg[3:0]};
        end
        rd_addr = {entry, s0_cnt_reg[0], s0_cnt_reg[1]};
        rd_hit  = 32'(rd_addr) < CB_DEPTH;
        px      = s0_x_reg + POS_W'(s0_cnt_reg[0]);
        py      = s0_y_reg + POS_W'({s0_cnt_reg[2], s0_cnt_reg[1]});
    end

    assign wr_en = in_xfer && cmd == CMD_LOAD && 32'(code_addr) < CB_DEPTH;

    vqtbd_ram #(
        .WIDTH (16),
        .DEPTH (CB_DEPTH)
    ) u_codebook (
        .clk   (clk),
        .we    (wr_en),
        .waddr (code_addr[CB_AW-1:0]),
        .wdata (code_word),
        .re    (s1_en),
        .raddr (rd_addr[CB_AW-1:0]),
        .rdata (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_x_reg    <= px;
            s1_y_reg    <= py;
            s1_last_reg <= s0_last;
            s1_hit_reg  <= rd_hit;
        end
        if (s2_en)
        begin
            s2_x_reg    <= s1_x_reg & SIDE_MASK;
            s2_y_reg    <= s1_y_reg & SIDE_MASK;
            s2_last_reg <= s1_last_reg;
            s2_rgb_reg  <= unpack_color(s1_hit_reg ? rd_word : 16'd0, color_format_reg);
        end
    end

    assign out_valid = s2_valid_reg;
    assign pix_x     = s2_x_reg;
    assign pix_y     = s2_y_reg;
    assign red       = s2_rgb_reg.red;
    assign green     = s2_rgb_reg.green;
    assign blue      = s2_rgb_reg.blue;
    assign last      = s2_last_reg;

endmodule

@@ sv/vqtbd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the VQ texture decoder, bound to the top level.
// Depends on vqtbd_pkg and vq_texture_block_decoder.
module vqtbd_checker
    import vqtbd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic        cfg_index,
    input logic [1:0]  cfg_data,
    input logic        out_valid,
    input logic        out_stall,
    input logic [9:0]  pix_x,
    input logic [9:0]  pix_y,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic        last
);

    logic [1:0] fmt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_RGB565;
        end
        else if (cfg_we && cfg_index == REG_COLOR_FORMAT)
        begin
            fmt_reg <= cfg_data;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pix_x) && $stable(pix_y)
            && $stable(red) && $stable(green) && $stable(blue) && $stable(last))
        else $error("stalled output changed");

    // pixels of one byte leave without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside a byte's pixel run");

    a_fmt_4444: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fmt_reg == FMT_ARGB4444
            |-> red[3:0] == 4'd0 && green[3:0] == 4'd0 && blue[3:0] == 4'd0)
        else $error("low bits set in 4444 output");

    a_fmt_5bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fmt_reg != FMT_ARGB4444 |-> red[2:0] == 3'd0 && blue[2:0] == 3'd0)
        else $error("low bits set in 5-bit channel");

endmodule

bind vq_texture_block_decoder vqtbd_checker u_vqtbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .last      (last)
);
